// ===== hw/rtl/vdht_pkg.sv =====
// ---------------------------------------------------------------------------
// Vector dedup hash table package
// Sizes, hash constants, command codes and float compare helpers.
// ---------------------------------------------------------------------------
package vdht_pkg;

   localparam int MAX_ENTRIES_DEF  = 1024;
   localparam int BUCKET_COUNT_DEF = 1024;

   localparam logic [31:0] HASH_MUL_X = 32'h9E37_79B1;
   localparam logic [31:0] HASH_MUL_Y = 32'h85EB_CA77;
   localparam logic [31:0] HASH_MUL_Z = 32'hC2B2_AE3D;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] DIM_TWO   = 2'd2;
   localparam logic [1:0] DIM_RESET = 2'd3;

   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0] EXP_ONES = 32'h7F80_0000;

   function automatic logic [31:0] canon_zero(input logic [31:0] c);
      return (c == NEG_ZERO) ? 32'd0 : c;
   endfunction

   function automatic logic is_nan(input logic [31:0] c);
      return {1'b0, c[30:0]} > EXP_ONES;
   endfunction

   function automatic logic comp_equal(input logic [31:0] a, input logic [31:0] b);
      return !is_nan(a) && !is_nan(b) && (canon_zero(a) == canon_zero(b));
   endfunction

endpackage

// ===== hw/rtl/vdht_ram.sv =====
// ---------------------------------------------------------------------------
// Vector dedup hash table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module vdht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/vector_dedup_hash_table.sv =====
// ---------------------------------------------------------------------------
// Vector dedup hash table
// Deduplicates 2- or 3-component float vectors through a chained hash table
// and returns the index of each vector's stored entry.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake           Contents
//  req      in         req_tvalid/tready   tuser cmd, tdata x, y, z
//  rsp      out        rsp_tvalid/tready   tuser is_new, table_full;
//                                          tdata vec_index, entry_total
//  csr      in         csr_wr_en           dimension
//
// An add is accepted, hashed on the shared multiplier (plus a reciprocal
// multiply, a quotient multiply, a subtract and at most 1 correcting subtract
// step when the bucket count is not a power of two), reads the bucket head,
// visits the chain one entry at a time, appends and responds. A clear goes
// straight to the response. The chain walk is bound by the one read port of
// the entry RAMs. Reset takes effect at once and needs no clearing pass. A
// stalled result is held while the next transaction is already accepted.
module vector_dedup_hash_table #(
   parameter int MAX_ENTRIES  = vdht_pkg::MAX_ENTRIES_DEF,
   parameter int BUCKET_COUNT = vdht_pkg::BUCKET_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // comp_x, comp_y, comp_z
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // vec_index, entry_total, zero pad
   output logic [1:0]  rsp_tuser,   // is_new, table_full
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // dimension
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int LINK_W = $clog2(MAX_ENTRIES + 1);
   localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int CHN_W  = 1 + BKT_W + LINK_W;

   localparam logic [LINK_W-1:0] NO_LINK  = LINK_W'(MAX_ENTRIES);
   localparam logic              IS_POW2  = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
   localparam logic [31:0]       BKT_NUM  = 32'(BUCKET_COUNT);
   localparam logic [31:0]       BKT_MASK = 32'(BUCKET_COUNT - 1);
   localparam logic [63:0]       RECIP_FULL = (64'd1 << 32) / 64'(BUCKET_COUNT);
   localparam logic [31:0]       RECIP    = RECIP_FULL[31:0];

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_X   = 4'd1;
   localparam logic [3:0] S_MUL_Y   = 4'd2;
   localparam logic [3:0] S_MUL_Z   = 4'd3;
   localparam logic [3:0] S_ACC_Z   = 4'd4;
   localparam logic [3:0] S_FOLD    = 4'd5;
   localparam logic [3:0] S_RED_M   = 4'd6;
   localparam logic [3:0] S_RED_Q   = 4'd7;
   localparam logic [3:0] S_RED_R   = 4'd8;
   localparam logic [3:0] S_RED_FIX = 4'd9;
   localparam logic [3:0] S_HEAD    = 4'd10;
   localparam logic [3:0] S_WALK    = 4'd11;
   localparam logic [3:0] S_APPEND  = 4'd12;
   localparam logic [3:0] S_LINK    = 4'd13;
   localparam logic [3:0] S_RESP    = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        dim_ff, dim_in;
   logic [LINK_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [31:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic              three_ff, three_in;
   logic [31:0]       h_ff, h_in;
   logic [31:0]       r_ff, r_in;
   logic [63:0]       prod_ff, prod_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic              first_ff, first_in;
   logic              last_valid_ff, last_valid_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic              last_first_ff, last_first_in;
   logic [BKT_W-1:0]  last_tag_ff, last_tag_in;
   logic [IDX_W-1:0]  res_index_ff, res_index_in;
   logic              res_new_ff, res_new_in;
   logic              res_full_ff, res_full_in;

   logic [9:0]        out_index_ff, out_index_in;
   logic [10:0]       out_total_ff, out_total_in;
   logic              out_new_ff, out_new_in;
   logic              out_full_ff, out_full_in;

   logic [31:0]       mul_a, mul_b;
   logic [31:0]       h_fold;
   logic [31:0]       idx_wide, total_wide;

   logic              head_wr_en, head_rd_en;
   logic [BKT_W-1:0]  head_rd_addr;
   logic [LINK_W-1:0] head_rd_data;

   logic              ent_wr_en, ent_rd_en;
   logic [IDX_W-1:0]  ent_rd_addr;
   logic [31:0]       sx_rd, sy_rd, sz_rd;

   logic              chn_wr_en;
   logic [IDX_W-1:0]  chn_wr_addr;
   logic [CHN_W-1:0]  chn_wr_data, chn_rd_data;
   logic              c_first;
   logic [BKT_W-1:0]  c_tag;
   logic [LINK_W-1:0] c_next;
   logic              walk_valid, walk_match;

   assign h_fold  = h_ff ^ {16'd0, h_ff[31:16]};
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   assign c_first = chn_rd_data[CHN_W-1];
   assign c_tag   = chn_rd_data[CHN_W-2 -: BKT_W];
   assign c_next  = chn_rd_data[LINK_W-1:0];

   assign walk_valid = !first_ff || (c_first && (c_tag == bucket_ff));
   assign walk_match = vdht_pkg::comp_equal(x_ff, sx_rd) && vdht_pkg::comp_equal(y_ff, sy_rd)
                       && (!three_ff || vdht_pkg::comp_equal(z_ff, sz_rd));

   assign idx_wide   = 32'(res_index_ff);
   assign total_wide = 32'(fill_ff);

   always_comb begin
      state_in      = state_ff;
      dim_in        = csr_wr_en ? csr_wr_data : dim_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      three_in      = three_ff;
      h_in          = h_ff;
      r_in          = r_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      first_in      = first_ff;
      last_valid_in = last_valid_ff;
      last_in       = last_ff;
      last_first_in = last_first_ff;
      last_tag_in   = last_tag_ff;
      res_index_in  = res_index_ff;
      res_new_in    = res_new_ff;
      res_full_in   = res_full_ff;
      out_index_in  = out_index_ff;
      out_total_in  = out_total_ff;
      out_new_in    = out_new_ff;
      out_full_in   = out_full_ff;
      mul_a         = vdht_pkg::canon_zero(x_ff);
      mul_b         = vdht_pkg::HASH_MUL_X;
      head_wr_en    = 1'b0;
      head_rd_en    = 1'b0;
      head_rd_addr  = r_ff[BKT_W-1:0];
      ent_wr_en     = 1'b0;
      ent_rd_en     = 1'b0;
      ent_rd_addr   = cur_ff[IDX_W-1:0];
      chn_wr_en     = 1'b0;
      chn_wr_addr   = fill_ff[IDX_W-1:0];
      chn_wr_data   = {!last_valid_ff, bucket_ff, NO_LINK};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in         = req_tdata[31:0];
               y_in         = req_tdata[63:32];
               z_in         = req_tdata[95:64];
               three_in     = (dim_ff != vdht_pkg::DIM_TWO);
               res_index_in = '0;
               res_new_in   = 1'b0;
               res_full_in  = 1'b0;
               if (req_tuser == vdht_pkg::CMD_CLEAR) begin
                  fill_in  = '0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_MUL_X;
               end
            end
         end
         S_MUL_X: begin
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            h_in     = prod_ff[31:0];
            mul_a    = vdht_pkg::canon_zero(y_ff);
            mul_b    = vdht_pkg::HASH_MUL_Y;
            state_in = S_MUL_Z;
         end
         S_MUL_Z: begin
            h_in     = h_ff ^ prod_ff[31:0];
            mul_a    = vdht_pkg::canon_zero(z_ff);
            mul_b    = vdht_pkg::HASH_MUL_Z;
            state_in = three_ff ? S_ACC_Z : S_FOLD;
         end
         S_ACC_Z: begin
            h_in     = h_ff ^ prod_ff[31:0];
            state_in = S_FOLD;
         end
         S_FOLD: begin
            h_in = h_fold;
            if (IS_POW2) begin
               r_in     = h_fold & BKT_MASK;
               state_in = S_RED_FIX;
            end else begin
               state_in = S_RED_M;
            end
         end
         S_RED_M: begin
            mul_a    = h_ff;
            mul_b    = RECIP;
            state_in = S_RED_Q;
         end
         S_RED_Q: begin
            mul_a    = prod_ff[63:32];
            mul_b    = BKT_NUM;
            state_in = S_RED_R;
         end
         S_RED_R: begin
            r_in     = h_ff - prod_ff[31:0];
            state_in = S_RED_FIX;
         end
         S_RED_FIX: begin
            if (r_ff >= BKT_NUM) begin
               r_in = r_ff - BKT_NUM;
            end else begin
               bucket_in  = r_ff[BKT_W-1:0];
               head_rd_en = 1'b1;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            cur_in        = head_rd_data;
            first_in      = 1'b1;
            last_valid_in = 1'b0;
            if (head_rd_data < fill_ff) begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = head_rd_data[IDX_W-1:0];
               state_in    = S_WALK;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_WALK: begin
            if (!walk_valid) begin
               state_in = S_APPEND;
            end else if (walk_match) begin
               res_index_in = cur_ff[IDX_W-1:0];
               state_in     = S_RESP;
            end else begin
               last_in       = cur_ff[IDX_W-1:0];
               last_valid_in = 1'b1;
               last_first_in = c_first;
               last_tag_in   = c_tag;
               first_in      = 1'b0;
               if (c_next < fill_ff) begin
                  cur_in      = c_next;
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = c_next[IDX_W-1:0];
               end else begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            if (fill_ff == NO_LINK) begin
               res_full_in = 1'b1;
               state_in    = S_RESP;
            end else begin
               ent_wr_en    = 1'b1;
               chn_wr_en    = 1'b1;
               head_wr_en   = !last_valid_ff;
               res_index_in = fill_ff[IDX_W-1:0];
               res_new_in   = 1'b1;
               fill_in      = fill_ff + LINK_W'(1);
               state_in     = last_valid_ff ? S_LINK : S_RESP;
            end
         end
         S_LINK: begin
            chn_wr_en   = 1'b1;
            chn_wr_addr = last_ff;
            chn_wr_data = {last_first_ff, last_tag_ff, LINK_W'(res_index_ff)};
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_index_in = idx_wide[9:0];
               out_total_in = total_wide[10:0];
               out_new_in   = res_new_ff;
               out_full_in  = res_full_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_ff       <= vdht_pkg::DIM_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      three_ff      <= three_in;
      h_ff          <= h_in;
      r_ff          <= r_in;
      prod_ff       <= prod_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      first_ff      <= first_in;
      last_valid_ff <= last_valid_in;
      last_ff       <= last_in;
      last_first_ff <= last_first_in;
      last_tag_ff   <= last_tag_in;
      res_index_ff  <= res_index_in;
      res_new_ff    <= res_new_in;
      res_full_ff   <= res_full_in;
      out_index_ff  <= out_index_in;
      out_total_ff  <= out_total_in;
      out_new_ff    <= out_new_in;
      out_full_ff   <= out_full_in;
   end

   vdht_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (fill_ff),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   vdht_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_store_x_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (x_ff),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (sx_rd)
   );

   vdht_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_store_y_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (y_ff),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (sy_rd)
   );

   vdht_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_store_z_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (z_ff),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (sz_rd)
   );

   vdht_ram #(.WIDTH(CHN_W), .DEPTH(MAX_ENTRIES)) u_chain_ram (
      .clock   (clock),
      .wr_en   (chn_wr_en),
      .wr_addr (chn_wr_addr),
      .wr_data (chn_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (chn_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, out_total_ff, out_index_ff};
   assign rsp_tuser  = {out_full_ff, out_new_ff};

endmodule

// ===== sim/vector_dedup_hash_table_tb.sv =====
// ---------------------------------------------------------------------------
// Vector dedup hash table testbench
// Streams add and clear transactions into the table and checks every
// response against a shadow copy of the chained table kept in the bench.
// Covers signed zeros, NaNs and infinities, dimension changes with entries
// stored, a completely filled table, and random traffic under sender idling,
// receiver stalls and a long receiver hold-off.
// ---------------------------------------------------------------------------
module vector_dedup_hash_table_tb;

   localparam int ENTRY_LIMIT = vdht_pkg::MAX_ENTRIES_DEF;
   localparam int BUCKETS = vdht_pkg::BUCKET_COUNT_DEF;
   localparam int IDX_BITS = $clog2(ENTRY_LIMIT);
   localparam int BKT_BITS = $clog2(BUCKETS);
   localparam logic [10:0] NO_LINK = 11'(ENTRY_LIMIT);
   localparam logic CMD_ADD = vdht_pkg::CMD_ADD;
   localparam logic CMD_CLEAR = vdht_pkg::CMD_CLEAR;
   localparam logic [1:0] DIM_TWO = vdht_pkg::DIM_TWO;
   localparam logic [1:0] DIM_RESET = vdht_pkg::DIM_RESET;
   localparam logic [31:0] NEG_ZERO = vdht_pkg::NEG_ZERO;
   localparam logic [31:0] EXP_ONES = vdht_pkg::EXP_ONES;
   localparam logic [31:0] HASH_MUL_X = vdht_pkg::HASH_MUL_X;
   localparam logic [31:0] HASH_MUL_Y = vdht_pkg::HASH_MUL_Y;
   localparam logic [31:0] HASH_MUL_Z = vdht_pkg::HASH_MUL_Z;
   localparam logic [1:0] DIM_ALIAS_0 = 2'd0;
   localparam logic [1:0] DIM_ALIAS_1 = 2'd1;
   localparam int SETTLE_CYCLES = 16;
   localparam int POOL_DEPTH = 48;
   localparam int PHASE_ITEMS = 110;

   typedef struct packed {
      logic [9:0]  vec_index;
      logic        is_new;
      logic        table_full;
      logic [10:0] entry_total;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // comp_x, comp_y, comp_z
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // vec_index, entry_total, zero pad
   logic [1:0]  rsp_tuser;        // is_new, table_full
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0; // dimension

   logic [31:0] shadow_x [ENTRY_LIMIT];
   logic [31:0] shadow_y [ENTRY_LIMIT];
   logic [31:0] shadow_z [ENTRY_LIMIT];
   logic [10:0] shadow_link [ENTRY_LIMIT];
   logic [10:0] shadow_head [BUCKETS];
   logic [10:0] shadow_fill;
   logic [1:0]  shadow_dim;

   lookup_result_type pending_results[$];

   logic [31:0] pool_x [POOL_DEPTH];
   logic [31:0] pool_y [POOL_DEPTH];
   logic [31:0] pool_z [POOL_DEPTH];
   int pool_size = 0;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int appends = 0;
   int repeats = 0;
   int overflows = 0;
   int clears = 0;

   vector_dedup_hash_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] unsigned_zero(input logic [31:0] c);
      return (c[30:0] == 31'd0) ? 32'd0 : c;
   endfunction

   function automatic logic float_nan(input logic [31:0] c);
      return (c[30:23] == 8'hFF) && (c[22:0] != 23'd0);
   endfunction

   function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
      return !float_nan(a) && !float_nan(b) && (unsigned_zero(a) == unsigned_zero(b));
   endfunction

   function automatic logic [BKT_BITS-1:0] bucket_index(input logic [31:0] x,
                                                        input logic [31:0] y,
                                                        input logic [31:0] z,
                                                        input logic three);
      logic [31:0] h;
      h = (unsigned_zero(x) * HASH_MUL_X) ^ (unsigned_zero(y) * HASH_MUL_Y);
      if (three) begin
         h = h ^ (unsigned_zero(z) * HASH_MUL_Z);
      end
      h = h ^ (h >> 16);
      return BKT_BITS'(h % 32'(BUCKETS));
   endfunction

   task automatic clear_shadow();
      for (int i = 0; i < BUCKETS; i++) begin
         shadow_head[i] = NO_LINK;
      end
      shadow_fill = '0;
   endtask

   task automatic dedup_lookup(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, output lookup_result_type r);
      logic [BKT_BITS-1:0] b;
      int steps;
      logic [10:0] cur;
      logic [10:0] last;
      logic three;
      logic found;
      r = '0;
      three = (shadow_dim != DIM_TWO);
      if (cmd == CMD_CLEAR) begin
         clear_shadow();
         clears++;
      end else begin
         b = bucket_index(x, y, z, three);
         cur = shadow_head[b];
         last = NO_LINK;
         steps = 0;
         found = 1'b0;
         while (!found && cur < shadow_fill && steps < shadow_fill) begin
            if (float_eq(x, shadow_x[cur[IDX_BITS-1:0]]) &&
                float_eq(y, shadow_y[cur[IDX_BITS-1:0]]) &&
                (!three || float_eq(z, shadow_z[cur[IDX_BITS-1:0]]))) begin
               found = 1'b1;
               r.vec_index = cur[9:0];
            end else begin
               last = cur;
               cur = shadow_link[cur[IDX_BITS-1:0]];
               steps++;
            end
         end
         if (found) begin
            repeats++;
         end else if (shadow_fill >= 11'(ENTRY_LIMIT)) begin
            r.table_full = 1'b1;
            overflows++;
         end else begin
            shadow_x[shadow_fill[IDX_BITS-1:0]] = x;
            shadow_y[shadow_fill[IDX_BITS-1:0]] = y;
            shadow_z[shadow_fill[IDX_BITS-1:0]] = z;
            shadow_link[shadow_fill[IDX_BITS-1:0]] = NO_LINK;
            if (last == NO_LINK) begin
               shadow_head[b] = shadow_fill;
            end else begin
               shadow_link[last[IDX_BITS-1:0]] = shadow_fill;
            end
            r.vec_index = shadow_fill[9:0];
            r.is_new = 1'b1;
            shadow_fill = shadow_fill + 11'd1;
            appends++;
         end
      end
      r.entry_total = shadow_fill;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40) begin
         $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   task automatic send_item(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      lookup_result_type r;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      dedup_lookup(cmd, x, y, z, r);
      pending_results.push_back(r);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [1:0] dim);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= dim;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_dim = dim;
   endtask

   function automatic logic [31:0] random_component();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return NEG_ZERO;
         2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom) | 23'd1};
         3: return $urandom_range(1) ? (EXP_ONES | NEG_ZERO) : EXP_ONES;
         4: return 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] flip_zero(input logic [31:0] c);
      return (c[30:0] == 31'd0 && $urandom_range(1)) ? (c ^ NEG_ZERO) : c;
   endfunction

   task automatic random_item();
      int pick;
      int slot;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 50 && pool_size > 0) begin
         slot = $urandom_range(pool_size - 1);
         x = flip_zero(pool_x[slot]);
         y = flip_zero(pool_y[slot]);
         z = ($urandom_range(3) == 0) ? $urandom : flip_zero(pool_z[slot]);
         send_item(CMD_ADD, x, y, z);
      end else begin
         x = random_component();
         y = random_component();
         z = random_component();
         slot = (pool_size < POOL_DEPTH) ? pool_size : $urandom_range(POOL_DEPTH - 1);
         if (pool_size < POOL_DEPTH) begin
            pool_size++;
         end
         pool_x[slot] = x;
         pool_y[slot] = y;
         pool_z[slot] = z;
         send_item(CMD_ADD, x, y, z);
      end
   endtask

   task automatic test_directed();
      send_item(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_ADD, NEG_ZERO, NEG_ZERO, NEG_ZERO);
      send_item(CMD_ADD, 32'h0000_0000, NEG_ZERO, 32'h0000_0000);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_ADD, EXP_ONES, EXP_ONES | NEG_ZERO, 32'h7F7F_FFFF);
      send_item(CMD_ADD, EXP_ONES, EXP_ONES | NEG_ZERO, 32'h7F7F_FFFF);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0001);
      send_item(CMD_ADD, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFF);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      send_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_dimension_switch();
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      write_dimension(DIM_TWO);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h40E0_0000);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      send_item(CMD_ADD, NEG_ZERO, 32'h0000_0000, 32'h1234_5678);
      write_dimension(DIM_RESET);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      send_item(CMD_ADD, 32'h3F80_0000, 32'h4000_0000, 32'h40E0_0000);
   endtask

   task automatic test_table_full();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < ENTRY_LIMIT; i++) begin
         send_item(CMD_ADD, 32'(i), $urandom & 32'h3FFF_FFFF, $urandom);
      end
      for (int i = 0; i < 3; i++) begin
         send_item(CMD_ADD, 32'(ENTRY_LIMIT + 100 + i), $urandom, $urandom);
      end
      send_item(CMD_ADD, NEG_ZERO, shadow_y[0], shadow_z[0]);
      send_item(CMD_ADD, shadow_x[ENTRY_LIMIT - 1], shadow_y[ENTRY_LIMIT - 1],
                shadow_z[ENTRY_LIMIT - 1]);
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input logic [1:0] dim);
      write_dimension(dim);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) random_item();
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, DIM_RESET);
      run_phase(80, 0, DIM_TWO);
      run_phase(0, 80, DIM_ALIAS_0);
      run_phase(38, 38, DIM_ALIAS_1);
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 400;
      repeat (40) random_item();
   endtask

   task automatic test_sender_pause();
      req_idle_pct = 20;
      rsp_stall_pct = 20;
      repeat (20) random_item();
      wait_idle();
      repeat (20) random_item();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, vec_index", rsp_tdata[9:0], 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[9:0] !== want.vec_index) begin
               report_mismatch("vec_index", rsp_tdata[9:0], want.vec_index);
            end
            if (rsp_tdata[20:10] !== want.entry_total) begin
               report_mismatch("entry_total", rsp_tdata[20:10], want.entry_total);
            end
            if (rsp_tuser[0] !== want.is_new) begin
               report_mismatch("is_new", rsp_tuser[0], want.is_new);
            end
            if (rsp_tuser[1] !== want.table_full) begin
               report_mismatch("table_full", rsp_tuser[1], want.table_full);
            end
            results_checked++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d responses outstanding.", pending_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clear_shadow();
      shadow_dim = DIM_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_dimension_switch();
      test_table_full();
      test_random_traffic();
      test_backpressure();
      test_sender_pause();
      wait_idle();
      repeat (64) @(posedge clock);
      $display("Ran %0d transactions: %0d appended, %0d found again, %0d refused, %0d clears.",
               items_sent, appends, repeats, overflows, clears);
      $display("Checked %0d responses across all dimension codes and idle/stall mixes.",
               results_checked);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/vdht_pkg.sv
hw/rtl/vdht_ram.sv
hw/rtl/vector_dedup_hash_table.sv
sim/vector_dedup_hash_table_tb.sv
